@@ hdl/lsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared constants and types of the LZSS stream decoder: token field widths,
// bit buffer sizing and the result record that travels to the output stage.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // Token format
    localparam int DIST_BITS          = 13;
    localparam int LEN_BITS           = 4;
    localparam int MIN_MATCH_LESS_ONE = 2;
    localparam int LIT_BITS           = 8;
    localparam int IN_BITS            = 8;

    // History ring
    localparam int RING_DEPTH = 1 << DIST_BITS;

    // Token sizes in bits
    localparam int LIT_TOK_BITS   = 1 + LIT_BITS;
    localparam int END_TOK_BITS   = 1 + LEN_BITS;
    localparam int MATCH_TOK_BITS = 1 + LEN_BITS + DIST_BITS;

    // Bit buffer holds at most one incomplete match token plus one input byte
    localparam int BUF_BITS = MATCH_TOK_BITS - 1 + IN_BITS;
    localparam int CNT_BITS = $clog2(BUF_BITS + 1);

    // Longest copy and the width of its down counter
    localparam int MAX_COPY = (1 << LEN_BITS) - 2 + MIN_MATCH_LESS_ONE + 1;
    localparam int CPY_BITS = $clog2(MAX_COPY + 1);

    // One decoded result
    typedef struct packed {
        logic                stream_end;
        logic                run_last;
        logic [LIT_BITS-1:0] out_byte;
    } t_result;

    // History port request from the decoder core
    typedef struct packed {
        logic                 we;
        logic [DIST_BITS-1:0] waddr;
        logic [LIT_BITS-1:0]  wdata;
        logic                 re;
        logic [DIST_BITS-1:0] raddr;
    } t_ram_req;

endpackage

@@ hdl/lzss_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// lzss_stream_decoder_unit
// LZSS stream decoder: compressed bytes in, decoded bytes out, with an
// 8 KiB history RAM and a two-entry output queue.
// ----------------------------------------------------------------------------
// Each accepted byte enters the bit buffer, and every complete token is then
// handled in turn: a literal is stored and emitted, a match of length L
// copies L bytes, and the parser goes back to idle once no complete token is
// left. No new byte is taken until then, and a full output queue can delay
// that further. The copy rate of one byte per cycle while the output queue
// has room is set by the single read port of the history RAM. Results queue
// in a two-entry buffer, so input is taken while decoded bytes still wait
// downstream. The history needs no clearing pass after reset: a wrap flag and
// the write position mark entries never written, which read as zero. After
// the end marker, input is taken and dropped.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_unit
    import lsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_BITS-1:0]  s_axis_tdata,   // [7:0] in_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [LIT_BITS-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic                m_axis_tlast,   // run_last
    output logic                m_axis_tuser    // [0] stream_end
);

    t_ram_req            ram_req;
    logic [LIT_BITS-1:0] ram_rdata;
    logic                emit_valid;
    logic                emit_ready;
    t_result             emit;

    t_result             r_ob [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_ocnt;
    logic                push;
    logic                pop;
    t_result             head;

    lsd_ram #(
        .WIDTH (LIT_BITS),
        .DEPTH (RING_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    lsd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .o_emit_valid (emit_valid),
        .i_emit_ready (emit_ready),
        .o_emit       (emit),
        .o_ram        (ram_req),
        .i_ram_rdata  (ram_rdata)
    );

    // Output queue handshakes
    assign emit_ready    = (r_ocnt != 2'd2);
    assign push          = emit_valid && emit_ready;
    assign m_axis_tvalid = (r_ocnt != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign head          = r_ob[r_rd_ptr];
    assign m_axis_tdata  = head.out_byte;
    assign m_axis_tlast  = head.run_last;
    assign m_axis_tuser  = head.stream_end;

    // Hold results until the transaction completes
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ob[r_wr_ptr] <= emit;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_ocnt   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("output queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt == 2'd0 || r_ocnt == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("output queue pointers disagree with count");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt == 2'd2 && !m_axis_tready |=> r_ocnt == 2'd2)
        else $error("full output queue lost an entry");
`endif

endmodule

@@ hdl/lsd_ram.sv @@
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is issued.
// ----------------------------------------------------------------------------
module lsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lsd_core.sv @@
// ----------------------------------------------------------------------------
// lsd_core
// Bit buffer, token parser and copy sequencer. Literals and copied bytes are
// written to the history RAM at the write position; copies read one byte a
// cycle unless stalled, forwarding the byte written in the same cycle on overlap.
// ----------------------------------------------------------------------------
module lsd_core
    import lsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [IN_BITS-1:0]  i_in_byte,
    output logic                o_emit_valid,
    input  logic                i_emit_ready,
    output t_result             o_emit,
    output t_ram_req            o_ram,
    input  logic [LIT_BITS-1:0] i_ram_rdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_COPY  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [BUF_BITS-1:0]  r_buf, n_buf;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_fin, n_fin;
    logic [DIST_BITS-1:0] r_wp, n_wp;
    logic                 r_wrap, n_wrap;
    logic [DIST_BITS-1:0] r_src, n_src;
    logic [CPY_BITS-1:0]  r_left, n_left;
    logic                 r_pend, n_pend;
    logic                 r_fwd, n_fwd;
    logic                 r_vld, n_vld;
    logic [LIT_BITS-1:0]  r_wbyte, n_wbyte;

    logic                 tok_rdy;
    logic                 is_end;
    logic [LIT_BITS-1:0]  lit;
    logic [LEN_BITS-1:0]  lenf;
    logic [DIST_BITS-1:0] distance;
    logic [BUF_BITS-1:0]  lit_buf, match_buf;
    logic [CNT_BITS-1:0]  lit_cnt, match_cnt;
    logic [LIT_BITS-1:0]  cpy_byte;
    logic                 step;

    // True when the buffer holds every bit of the next token
    function automatic logic tok_ready(input logic [BUF_BITS-1:0] b,
                                       input logic [CNT_BITS-1:0] c);
        logic lit_ok;
        logic mat_ok;
        lit_ok = !b[0] && (c >= CNT_BITS'(LIT_TOK_BITS));
        mat_ok = b[0] && (c >= CNT_BITS'(END_TOK_BITS)) &&
                 ((&b[LEN_BITS:1]) || (c >= CNT_BITS'(MATCH_TOK_BITS)));
        return lit_ok || mat_ok;
    endfunction

    // Decode the token at the head of the buffer
    assign tok_rdy   = tok_ready(r_buf, r_cnt);
    assign lit       = r_buf[LIT_BITS:1];
    assign lenf      = r_buf[LEN_BITS:1];
    assign distance  = r_buf[LEN_BITS+DIST_BITS:LEN_BITS+1];
    assign is_end    = &lenf;
    assign lit_buf   = r_buf >> LIT_TOK_BITS;
    assign lit_cnt   = r_cnt - CNT_BITS'(LIT_TOK_BITS);
    assign match_buf = r_buf >> MATCH_TOK_BITS;
    assign match_cnt = r_cnt - CNT_BITS'(MATCH_TOK_BITS);

    // Copy byte: forwarded write, history word, or zero for a never written entry
    assign cpy_byte = r_fwd ? r_wbyte : (r_vld ? i_ram_rdata : '0);

    assign o_in_ready = (r_state == ST_IDLE);
    assign step       = !r_pend || i_emit_ready;

    // Sequence tokens and copies
    always_comb begin
        n_state      = r_state;
        n_buf        = r_buf;
        n_cnt        = r_cnt;
        n_fin        = r_fin;
        n_wp         = r_wp;
        n_wrap       = r_wrap;
        n_src        = r_src;
        n_left       = r_left;
        n_pend       = r_pend;
        n_fwd        = r_fwd;
        n_vld        = r_vld;
        n_wbyte      = r_wbyte;
        o_emit_valid = 1'b0;
        o_emit       = '0;
        o_ram        = '0;
        case (r_state)
            ST_IDLE: begin
                // Append the byte, or drop it after the end marker
                if (i_in_valid && !r_fin) begin
                    n_buf   = r_buf | (BUF_BITS'(i_in_byte) << r_cnt);
                    n_cnt   = r_cnt + CNT_BITS'(IN_BITS);
                    n_state = ST_PARSE;
                end
            end
            ST_PARSE: begin
                if (!tok_rdy) begin
                    n_state = ST_IDLE;
                end else if (!r_buf[0]) begin
                    // Literal: store and emit
                    o_emit_valid    = 1'b1;
                    o_emit.out_byte = lit;
                    o_emit.run_last = !tok_ready(lit_buf, lit_cnt);
                    if (i_emit_ready) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_wp;
                        o_ram.wdata = lit;
                        n_wp        = r_wp + 1'b1;
                        n_wrap      = r_wrap | (&r_wp);
                        n_wbyte     = lit;
                        n_buf       = lit_buf;
                        n_cnt       = lit_cnt;
                    end
                end else if (is_end) begin
                    // End marker: one end result, then drop everything
                    o_emit_valid      = 1'b1;
                    o_emit.run_last   = 1'b1;
                    o_emit.stream_end = 1'b1;
                    if (i_emit_ready) begin
                        n_fin   = 1'b1;
                        n_buf   = '0;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                end else begin
                    // Match: load source and length
                    n_buf   = match_buf;
                    n_cnt   = match_cnt;
                    n_src   = r_wp - distance;
                    n_left  = CPY_BITS'(lenf) + CPY_BITS'(MIN_MATCH_LESS_ONE + 1);
                    n_pend  = 1'b0;
                    n_state = ST_COPY;
                end
            end
            ST_COPY: begin
                if (r_pend) begin
                    o_emit_valid    = 1'b1;
                    o_emit.out_byte = cpy_byte;
                    o_emit.run_last = (r_left == '0) && !tok_rdy;
                end
                if (step) begin
                    // Store and emit the byte that arrived
                    if (r_pend) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_wp;
                        o_ram.wdata = cpy_byte;
                        n_wp        = r_wp + 1'b1;
                        n_wrap      = r_wrap | (&r_wp);
                        n_wbyte     = cpy_byte;
                    end
                    // Issue the next read, flagging overlap and unwritten entries
                    if (r_left != '0) begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_src;
                        n_src       = r_src + 1'b1;
                        n_left      = r_left - 1'b1;
                        n_pend      = 1'b1;
                        n_fwd       = r_pend && (r_src == r_wp);
                        n_vld       = n_wrap || (r_src < n_wp);
                    end else begin
                        n_pend  = 1'b0;
                        n_state = ST_PARSE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_wp    <= '0;
            r_wrap  <= 1'b0;
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
            r_wp    <= n_wp;
            r_wrap  <= n_wrap;
            r_pend  <= n_pend;
            r_left  <= n_left;
        end
    end

    // Copy datapath registers
    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_fwd   <= n_fwd;
        r_vld   <= n_vld;
        r_wbyte <= n_wbyte;
    end

`ifndef SYNTHESIS
    a_pend_in_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_state == ST_COPY)
        else $error("read in flight outside a copy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(BUF_BITS))
        else $error("bit buffer overfilled");
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !o_emit_valid && r_cnt == '0)
        else $error("activity after end marker");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit_valid && o_emit.stream_end |-> o_emit.run_last && o_emit.out_byte == '0)
        else $error("malformed end result");
    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |=> r_wp == $past(r_wp) + 1'b1)
        else $error("write position did not advance");
`endif

endmodule

@@ sim/tb_lzss_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_lzss_stream_decoder_unit
// Self-checking bench for the LZSS stream decoder. An on-the-fly token encoder
// packs literal, match and end tokens into compressed bytes, and a bit-level
// decoder model predicts every decoded byte with its tlast and tuser flags.
// Sender bursts and receiver stalls vary between phases.
// ----------------------------------------------------------------------------
module tb_lzss_stream_decoder_unit;
    import lsd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 430;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [LEN_BITS-1:0] END_LEN = '1;
    localparam logic [LEN_BITS-1:0] MAX_LEN = END_LEN - 1'b1;

    typedef enum int {TOK_LITERAL, TOK_MATCH} t_tok_kind;
    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC} t_rdy_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata = '0;   // [7:0] in_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [LIT_BITS-1:0] m_axis_tdata;        // [7:0] out_byte
    logic                m_axis_tlast;        // run_last
    logic                m_axis_tuser;        // [0] stream_end

    // Decoder model state
    logic [31:0]          pend_bits;
    int                   pend_n;
    logic [LIT_BITS-1:0]  hist [RING_DEPTH];
    logic [DIST_BITS-1:0] wpos;
    bit                   stream_done;
    t_result              decoded_q[$];

    // Token encoder state
    logic [63:0] enc_acc;
    int          enc_n;

    // Traffic shaping and bookkeeping
    bit        gaps_on;
    int        burst_left;
    t_rdy_mode rdy_mode;
    int        rdy_cnt;
    int        cycles;
    int        err_cnt;
    int        bytes_sent;
    int        bytes_checked;
    int        lit_tokens;
    int        match_tokens;

    lzss_stream_decoder_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, decoded_q.size());
            $display("tb_lzss_stream_decoder_unit: done, errors");
            $finish;
        end
    end

    // Receiver stall pattern
    always @(posedge i_clk) begin
        rdy_cnt <= rdy_cnt + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS:   m_axis_tready <= 1'b1;
                RDY_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
                RDY_PERIODIC: m_axis_tready <= (rdy_cnt % 16) < 9;
                default:      m_axis_tready <= 1'b1;
            endcase
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, want %0h (result %0d)",
                 $time, what, got, want, bytes_checked);
        err_cnt++;
    endtask

    // Compare each output transaction with the oldest decoded byte waiting
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                report("unexpected result", m_axis_tdata, 0);
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.out_byte)
                    report("out_byte", m_axis_tdata, want.out_byte);
                if (m_axis_tlast !== want.run_last)
                    report("run_last", m_axis_tlast, want.run_last);
                if (m_axis_tuser !== want.stream_end)
                    report("stream_end", m_axis_tuser, want.stream_end);
            end
            bytes_checked++;
        end
    end

    // Advance the decoder model by one compressed byte
    function automatic void decode_byte(input logic [IN_BITS-1:0] b);
        logic [LIT_BITS-1:0]  lit;
        logic [LIT_BITS-1:0]  cp;
        logic [LEN_BITS-1:0]  lf;
        logic [DIST_BITS-1:0] distance;
        logic [DIST_BITS-1:0] src;
        int                   len;
        bit                   stop;
        t_result              run_q[$];
        if (stream_done)
            return;
        pend_bits = pend_bits | (32'(b) << pend_n);
        pend_n += IN_BITS;
        stop = 1'b0;
        while (!stop && pend_n >= 1) begin
            if (pend_bits[0] == 1'b0) begin
                if (pend_n < LIT_TOK_BITS) begin
                    stop = 1'b1;
                end else begin
                    lit = pend_bits[LIT_BITS:1];
                    pend_bits = pend_bits >> LIT_TOK_BITS;
                    pend_n -= LIT_TOK_BITS;
                    hist[wpos] = lit;
                    wpos = wpos + 1'b1;
                    run_q.push_back('{stream_end: 1'b0, run_last: 1'b0, out_byte: lit});
                end
            end else if (pend_n < END_TOK_BITS) begin
                stop = 1'b1;
            end else begin
                lf = pend_bits[LEN_BITS:1];
                if (lf == END_LEN) begin
                    // End marker: drop everything behind it
                    stream_done = 1'b1;
                    pend_bits = '0;
                    pend_n = 0;
                    run_q.push_back('{stream_end: 1'b1, run_last: 1'b0, out_byte: '0});
                    stop = 1'b1;
                end else if (pend_n < MATCH_TOK_BITS) begin
                    stop = 1'b1;
                end else begin
                    distance = pend_bits[END_TOK_BITS +: DIST_BITS];
                    pend_bits = pend_bits >> MATCH_TOK_BITS;
                    pend_n -= MATCH_TOK_BITS;
                    src = wpos - distance;
                    len = int'(lf) + MIN_MATCH_LESS_ONE + 1;
                    // Copy one byte at a time so overlaps repeat data
                    for (int k = 0; k < len; k++) begin
                        cp = hist[src];
                        hist[wpos] = cp;
                        wpos = wpos + 1'b1;
                        src = src + 1'b1;
                        run_q.push_back('{stream_end: 1'b0, run_last: 1'b0, out_byte: cp});
                    end
                end
            end
        end
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].run_last = 1'b1;
            foreach (run_q[i])
                decoded_q.push_back(run_q[i]);
        end
    endfunction

    // Send one compressed byte; called and returns at a rising edge
    task automatic send_byte(input logic [IN_BITS-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        decode_byte(b);
    endtask

    // Append bits to the compressed stream, least significant first
    task automatic put_bits(input logic [31:0] v, input int n);
        enc_acc = enc_acc | ((64'(v) & ((64'd1 << n) - 64'd1)) << enc_n);
        enc_n += n;
        while (enc_n >= IN_BITS) begin
            send_byte(enc_acc[IN_BITS-1:0]);
            enc_acc = enc_acc >> IN_BITS;
            enc_n -= IN_BITS;
        end
    endtask

    task automatic put_literal(input logic [LIT_BITS-1:0] lit);
        lit_tokens++;
        put_bits(32'({lit, 1'b0}), LIT_TOK_BITS);
    endtask

    task automatic put_match(input logic [LEN_BITS-1:0] lf,
                             input logic [DIST_BITS-1:0] distance);
        match_tokens++;
        put_bits(32'({distance, lf, 1'b1}), MATCH_TOK_BITS);
    endtask

    // Hold the input idle until every predicted result has left the block
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    task automatic test_literals();
        gaps_on  = 1'b0;
        rdy_mode = RDY_ALWAYS;
        put_literal(8'h00);
        put_literal(8'hFF);
        put_literal(8'hA5);
        put_literal(8'h5A);
    endtask

    task automatic test_matches();
        rdy_mode = RDY_RANDOM;
        // Distance zero re-stores the byte at the write position
        put_match('0, '0);
        // Overlapping copy of the longest length
        put_match(MAX_LEN, 13'd1);
        // Farthest distance wraps into entries never written
        put_match('0, '1);
        put_match(4'd5, 13'd7);
        put_literal(8'h3C);
        put_match(4'd9, 13'd2);
    endtask

    // Split a match token across a byte boundary and drain in the middle
    task automatic test_split_token();
        logic [DIST_BITS-1:0] distance;
        int                   head;
        gaps_on  = 1'b1;
        rdy_mode = RDY_PERIODIC;
        distance = 13'd5;
        match_tokens++;
        put_bits(32'({4'd3, 1'b1}), END_TOK_BITS);
        head = (IN_BITS - enc_n) % IN_BITS;
        put_bits(32'(distance), head);
        wait_drain();
        put_bits(32'(distance >> head), DIST_BITS - head);
        put_literal(8'h81);
    endtask

    task automatic put_random_token();
        t_tok_kind            kind;
        logic [LEN_BITS-1:0]  lf;
        logic [DIST_BITS-1:0] distance;
        int                   pick;
        kind = ($urandom_range(0, 99) < 55) ? TOK_LITERAL : TOK_MATCH;
        if (kind == TOK_LITERAL) begin
            put_literal(LIT_BITS'($urandom));
        end else begin
            lf = ($urandom_range(0, 6) == 0) ? MAX_LEN : LEN_BITS'($urandom_range(0, MAX_LEN));
            pick = $urandom_range(0, 9);
            if (pick < 5)
                distance = DIST_BITS'($urandom_range(0, 16));
            else if (pick < 9)
                distance = DIST_BITS'($urandom);
            else
                distance = '1;
            put_match(lf, distance);
        end
    endtask

    // Random token streams under changing sender and receiver behavior
    task automatic test_random();
        int target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            case ($urandom_range(0, 3))
                0: begin gaps_on = 1'b0; rdy_mode = RDY_ALWAYS;   end
                1: begin gaps_on = 1'b1; rdy_mode = RDY_RANDOM;   end
                2: begin gaps_on = 1'b1; rdy_mode = RDY_PERIODIC; end
                default: begin gaps_on = 1'b0; rdy_mode = RDY_RANDOM; end
            endcase
            repeat ($urandom_range(20, 60)) begin
                if (bytes_sent < target)
                    put_random_token();
            end
        end
    endtask

    // End marker recognized without a distance field; later input is dropped
    task automatic test_end_marker();
        gaps_on  = 1'b1;
        rdy_mode = RDY_RANDOM;
        put_bits(32'({END_LEN, 1'b1}), END_TOK_BITS);
        if (enc_n > 0)
            put_bits($urandom, IN_BITS - enc_n);
        repeat (4)
            send_byte(IN_BITS'($urandom));
        wait_drain();
    endtask

    initial begin
        pend_bits = '0;
        pend_n = 0;
        wpos = '0;
        stream_done = 1'b0;
        enc_acc = '0;
        enc_n = 0;
        gaps_on = 1'b0;
        burst_left = 0;
        rdy_mode = RDY_ALWAYS;
        rdy_cnt = 0;
        cycles = 0;
        err_cnt = 0;
        bytes_sent = 0;
        bytes_checked = 0;
        lit_tokens = 0;
        match_tokens = 0;
        foreach (hist[i])
            hist[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_literals();
        test_matches();
        test_split_token();
        test_random();
        test_end_marker();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report("results never delivered", 0, decoded_q.size());

        $display("covered %0d compressed bytes: %0d literal and %0d match tokens, end marker",
                 bytes_sent, lit_tokens, match_tokens);
        $display("checked %0d decoded results under input gaps and output stalls",
                 bytes_checked);
        if (err_cnt == 0)
            $display("tb_lzss_stream_decoder_unit: done, clean");
        else
            $display("tb_lzss_stream_decoder_unit: done, errors");
        $finish;
    end

endmodule
